[design/dgw_pkg.sv]
// Shared constants, types and font lookup for the decimal glyph writer.
package dgw_pkg;

    localparam int DIGIT_COUNT     = 5;
    localparam int GLYPH_WIDTH     = 5;
    localparam int FONT_COLS       = 5;
    localparam int CMD_BYTES       = 3;
    localparam int BYTES_PER_DIGIT = CMD_BYTES + GLYPH_WIDTH;
    localparam int VALUE_W         = 16;
    localparam int BCD_DIGITS      = 5;
    localparam int BCD_W           = 4 * BCD_DIGITS;
    localparam int CNT_W           = $clog2(VALUE_W);
    localparam int DIG_W           = (DIGIT_COUNT > 1) ? $clog2(DIGIT_COUNT) : 1;
    localparam int POS_W           = $clog2(BYTES_PER_DIGIT);

    localparam logic [3:0] CMD_COL_HI = 4'h1;
    localparam logic [3:0] CMD_COL_LO = 4'h0;
    localparam logic [3:0] CMD_PAGE   = 4'hB;

    typedef enum logic {
        F_IDLE,
        F_CONV
    } front_state_t;

    typedef struct packed {
        logic [DIGIT_COUNT-1:0][3:0] digits;  // index 0 = units
        logic [3:0]                  page;
        logic [7:0]                  column;
    } item_t;

    // all five columns of one digit in the 5x7 font; unused codes give blank columns
    function automatic logic [39:0] glyph_row(input logic [3:0] digit);
        logic [39:0] row;
        case (digit)
            4'd0:    row = 40'h3E_51_49_45_3E;
            4'd1:    row = 40'h00_42_7F_40_00;
            4'd2:    row = 40'h42_61_51_49_46;
            4'd3:    row = 40'h21_41_45_4B_31;
            4'd4:    row = 40'h18_14_12_7F_10;
            4'd5:    row = 40'h27_45_45_45_39;
            4'd6:    row = 40'h3C_4A_49_49_30;
            4'd7:    row = 40'h01_71_09_05_03;
            4'd8:    row = 40'h36_49_49_49_36;
            4'd9:    row = 40'h06_49_49_29_1E;
            default: row = 40'h0;
        endcase
        return row;
    endfunction

    function automatic logic [7:0] glyph_col(input logic [3:0] digit, input logic [2:0] col);
        logic [39:0] row;
        logic [7:0]  res;
        row = glyph_row(digit);
        case (col)
            3'd0:    res = row[39:32];
            3'd1:    res = row[31:24];
            3'd2:    res = row[23:16];
            3'd3:    res = row[15:8];
            3'd4:    res = row[7:0];
            default: res = 8'h00;
        endcase
        return res;
    endfunction

endpackage

[design/decimal_glyph_writer_core.sv]
// Top level of the decimal glyph writer: front end, queue and byte emitter.
//
// Each input word (value, page, start_column) turns into a run of forty LCD
// bytes: for each of the five decimal digits, most significant first and with
// leading zeros, three command bytes (column high nibble 0x10+hi, column low
// nibble, page 0xB0+page) followed by the five glyph columns of the digit,
// with is_data high on the glyph bytes and last high on the fortieth byte.
// The column advances by five per digit and wraps at 256. While out_ready
// stays high the back end emits one byte per cycle into a registered output.
// The front end converts the value to BCD (shift-and-add-3, one bit per
// cycle, holding the last bit while the queue is full) and parks the result
// in a two-entry queue, so conversion of the next word overlaps emission of
// the current one and runs continue back to back with no gap byte. On an idle
// block a word passes the converter, the queue, the current-word register and the output register.
module decimal_glyph_writer_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [15:0] value,
    input  logic [3:0]  page,
    input  logic [7:0]  start_column,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  lcd_byte,
    output logic        is_data,
    output logic        last
);
    import dgw_pkg::*;

    // front -> queue
    logic   push;
    item_t  push_item;
    logic   q_full;

    // queue -> back
    logic   pop;
    logic   q_valid;
    item_t  q_item;

    dgw_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .value        (value),
        .page         (page),
        .start_column (start_column),
        .push         (push),
        .push_item    (push_item),
        .q_full       (q_full)
    );

    dgw_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .full      (q_full),
        .pop       (pop),
        .q_valid   (q_valid),
        .q_item    (q_item)
    );

    // byte emitter owns the output register
    dgw_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_item    (q_item),
        .pop       (pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .lcd_byte  (lcd_byte),
        .is_data   (is_data),
        .last      (last)
    );

endmodule

[design/dgw_front.sv]
// Front end: accepts words; BCD one bit per cycle, last held on full queue.
module dgw_front (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [15:0]          value,
    input  logic [3:0]           page,
    input  logic [7:0]           start_column,
    output logic                 push,
    output dgw_pkg::item_t       push_item,
    input  logic                 q_full
);
    import dgw_pkg::*;

    front_state_t        state_reg, state_next;
    logic [VALUE_W-1:0]  bin_reg, bin_next;
    logic [BCD_W-1:0]    bcd_reg, bcd_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic [3:0]          page_reg, page_next;
    logic [7:0]          col_reg, col_next;

    logic                accept;
    logic                done;
    logic                step;
    logic [BCD_W-1:0]    bcd_adj;
    logic [BCD_W-1:0]    bcd_step;

    // add-3 on every nibble at or above five, then shift in the next bit
    always_comb
    begin
        for (int i = 0; i < BCD_DIGITS; i++)
        begin
            bcd_adj[4*i +: 4] = (bcd_reg[4*i +: 4] >= 4'd5) ?
                                bcd_reg[4*i +: 4] + 4'd3 : bcd_reg[4*i +: 4];
        end
        bcd_step = {bcd_adj[BCD_W-2:0], bin_reg[VALUE_W-1]};
    end

    always_comb
    begin
        done = (state_reg == F_CONV) && (cnt_reg == CNT_W'(VALUE_W - 1));
        push = done && !q_full;
        step = (state_reg == F_CONV) && (!done || !q_full);
    end

    // outputs
    always_comb
    begin
        case (state_reg)
            F_IDLE:  in_ready = 1'b1;
            F_CONV:  in_ready = push;
            default: in_ready = 1'b0;
        endcase
        accept = in_valid && in_ready;
        push_item.digits = bcd_step[4*DIGIT_COUNT-1:0];
        push_item.page   = page_reg;
        push_item.column = col_reg;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            F_IDLE:
            begin
                if (accept)
                    state_next = F_CONV;
            end
            F_CONV:
            begin
                if (push && !accept)
                    state_next = F_IDLE;
            end
            default: state_next = F_IDLE;
        endcase
    end

    always_comb
    begin
        bin_next  = bin_reg;
        bcd_next  = bcd_reg;
        cnt_next  = cnt_reg;
        page_next = page_reg;
        col_next  = col_reg;
        if (accept)
        begin
            bin_next  = value;
            bcd_next  = '0;
            cnt_next  = '0;
            page_next = page;
            col_next  = start_column;
        end
        else if (step)
        begin
            bin_next = {bin_reg[VALUE_W-2:0], 1'b0};
            bcd_next = bcd_step;
            cnt_next = cnt_reg + CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bin_reg  <= bin_next;
        bcd_reg  <= bcd_next;
        page_reg <= page_next;
        col_reg  <= col_next;
    end

endmodule

[design/dgw_queue.sv]
// Two-entry queue of converted words between front and back end.
module dgw_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  dgw_pkg::item_t  push_item,
    output logic            full,
    input  logic            pop,
    output logic            q_valid,
    output dgw_pkg::item_t  q_item
);
    import dgw_pkg::*;

    item_t       mem_reg [2];
    logic        wr_ptr_reg, wr_ptr_next;
    logic        rd_ptr_reg, rd_ptr_next;
    logic [1:0]  count_reg, count_next;

    always_comb
    begin
        full    = (count_reg == 2'd2);
        q_valid = (count_reg != 2'd0);
        q_item  = mem_reg[rd_ptr_reg];
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ pop;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_item;
    end

endmodule

[design/dgw_back.sv]
// Back end: walks digits and byte slots, one LCD byte per cycle into an output register unless stalled.
module dgw_back (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            q_valid,
    input  dgw_pkg::item_t  q_item,
    output logic            pop,
    output logic            out_valid,
    input  logic            out_ready,
    output logic [7:0]      lcd_byte,
    output logic            is_data,
    output logic            last
);
    import dgw_pkg::*;

    item_t             cur_reg, cur_next;
    logic              act_reg, act_next;
    logic [DIG_W-1:0]  dig_reg, dig_next;
    logic [POS_W-1:0]  pos_reg, pos_next;
    logic [7:0]        col_reg, col_next;
    logic              ov_reg, ov_next;
    logic [7:0]        byte_reg, byte_next;
    logic              data_reg, data_next;
    logic              last_reg, last_next;

    logic              adv;
    logic              digit_end;
    logic              run_end;
    logic [3:0]        digit;
    logic [POS_W-1:0]  gcol;
    logic [7:0]        cur_byte;

    always_comb
    begin
        adv       = act_reg && (!ov_reg || out_ready);
        digit_end = (pos_reg == POS_W'(BYTES_PER_DIGIT - 1));
        run_end   = digit_end && (dig_reg == '0);
        pop       = q_valid && (!act_reg || (adv && run_end));
        digit     = cur_reg.digits[dig_reg];
        gcol      = pos_reg - POS_W'(CMD_BYTES);
        if (pos_reg == POS_W'(0))
            cur_byte = {CMD_COL_HI, col_reg[7:4]};
        else if (pos_reg == POS_W'(1))
            cur_byte = {CMD_COL_LO, col_reg[3:0]};
        else if (pos_reg == POS_W'(2))
            cur_byte = {CMD_PAGE, cur_reg.page};
        else if (32'(gcol) < 32'(FONT_COLS))
            cur_byte = glyph_col(digit, 3'(gcol));
        else
            cur_byte = 8'h00;
    end

    always_comb
    begin
        cur_next  = cur_reg;
        act_next  = act_reg;
        dig_next  = dig_reg;
        pos_next  = pos_reg;
        col_next  = col_reg;
        ov_next   = ov_reg && !out_ready;
        byte_next = byte_reg;
        data_next = data_reg;
        last_next = last_reg;
        if (adv)
        begin
            ov_next   = 1'b1;
            byte_next = cur_byte;
            data_next = (pos_reg >= POS_W'(CMD_BYTES));
            last_next = run_end;
            if (digit_end)
            begin
                pos_next = '0;
                dig_next = dig_reg - DIG_W'(1);
                col_next = col_reg + 8'(GLYPH_WIDTH);
                if (run_end)
                    act_next = 1'b0;
            end
            else
            begin
                pos_next = pos_reg + POS_W'(1);
            end
        end
        if (pop)
        begin
            cur_next = q_item;
            act_next = 1'b1;
            dig_next = DIG_W'(DIGIT_COUNT - 1);
            pos_next = '0;
            col_next = q_item.column;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            act_reg <= 1'b0;
            ov_reg  <= 1'b0;
            dig_reg <= '0;
            pos_reg <= '0;
        end
        else
        begin
            act_reg <= act_next;
            ov_reg  <= ov_next;
            dig_reg <= dig_next;
            pos_reg <= pos_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg  <= cur_next;
        col_reg  <= col_next;
        byte_reg <= byte_next;
        data_reg <= data_next;
        last_reg <= last_next;
    end

    assign out_valid = ov_reg;
    assign lcd_byte  = byte_reg;
    assign is_data   = data_reg;
    assign last      = last_reg;

endmodule

[design/dgw_checker.sv]
// Port-level checks for the decimal glyph writer, bound to the top level.
module dgw_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_ready,
    input logic [7:0] lcd_byte,
    input logic       is_data,
    input logic       last
);
    import dgw_pkg::*;

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("output word dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(lcd_byte) && $stable(is_data) && $stable(last))
        else $error("output word changed while stalled");

    a_last_is_data: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && last |-> is_data)
        else $error("run ended on a command byte");

    a_cmd_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !is_data |->
            (lcd_byte[7:4] == CMD_COL_HI || lcd_byte[7:4] == CMD_COL_LO ||
             lcd_byte[7:4] == CMD_PAGE))
        else $error("command byte with unknown opcode");

endmodule

bind decimal_glyph_writer_core dgw_checker u_dgw_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .lcd_byte  (lcd_byte),
    .is_data   (is_data),
    .last      (last)
);
